/* rtl/core/assert_macros.svh */
// Assertion macros used by the message ring queue engine (mrq_back).
// Expects clk and rst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define MRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define MRQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/mrq_pkg.sv */
// Package of the message ring queue: sizes, codes, item types and helpers.
// No dependencies; used by every module under rtl/core.
package mrq_pkg;

  localparam int SLOTS     = 16;
  localparam int MSG_BYTES = 64;

  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS);
  localparam int LEN_W     = 7;
  localparam int OCC_W     = 4;
  localparam int DATA_W    = 8;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int MEM_DEPTH = SLOTS * MSG_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam int OUT_TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DROP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd3;

  typedef enum logic [1:0] {
    K_PUSH,
    K_POP,
    K_DROP,
    K_NOP
  } mrq_kind_t;

  typedef struct packed {
    mrq_kind_t         kind;
    logic [DATA_W-1:0] data;
    logic              last;
  } mrq_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              last;
    logic [OCC_W-1:0]  occupancy;
  } mrq_result_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LEN_W-1:0]  off);
    byte_addr = ADDR_W'(s) * ADDR_W'(MSG_BYTES) + ADDR_W'(off);
  endfunction

endpackage

/* rtl/core/mrq_front.sv */
// Input stage of the message ring queue: registers and classifies commands.
// Depends on mrq_pkg.
module mrq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mrq_pkg::DATA_W-1:0]   in_tdata,   // [7:0] data_in
  input  logic                         in_tlast,
  input  logic [mrq_pkg::CMD_W-1:0]    in_tuser,   // [1:0] cmd
  output logic                         item_valid,
  input  logic                         item_ready,
  output mrq_pkg::mrq_item_t           item
);
  import mrq_pkg::*;

  logic      valid_r;
  mrq_item_t item_r;
  mrq_kind_t kind;

  always_comb begin
    case (in_tuser)
      CMD_PUSH: kind = K_PUSH;
      CMD_POP:  kind = K_POP;
      CMD_DROP: kind = K_DROP;
      default:  kind = K_NOP;
    endcase
  end

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind <= kind;
      item_r.data <= in_tdata;
      item_r.last <= in_tlast;
    end
  end

endmodule

/* rtl/core/mrq_queue.sv */
// Short command queue between the input stage and the execution engine.
// Depends on mrq_pkg.
module mrq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  mrq_pkg::mrq_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output mrq_pkg::mrq_item_t rd_item
);
  import mrq_pkg::*;

  mrq_item_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_nxt;
  logic                do_wr;
  logic                do_rd;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* rtl/core/mrq_back.sv */
// Execution engine of the message ring queue: ring pointers, byte and length
// stores, pop streaming and the result register. Depends on mrq_pkg.
`include "assert_macros.svh"

module mrq_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  mrq_pkg::mrq_item_t   q_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mrq_pkg::mrq_result_t res
);
  import mrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EMIT
  } state_t;

  logic [DATA_W-1:0] byte_mem [MEM_DEPTH];
  logic [LEN_W-1:0]  len_mem  [SLOTS];

  state_t            state_r,   state_nxt;
  logic [SLOT_W-1:0] head_r,    head_nxt;
  logic [SLOT_W-1:0] tail_r,    tail_nxt;
  logic [CNT_W-1:0]  count_r,   count_nxt;
  logic [LEN_W-1:0]  fill_r,    fill_nxt;
  logic              rej_r,     rej_nxt;
  logic              ovf_r,     ovf_nxt;
  logic [SLOT_W-1:0] pslot_r,   pslot_nxt;
  logic [LEN_W-1:0]  plen_r,    plen_nxt;
  logic [LEN_W-1:0]  idx_r,     idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  mrq_result_t       res_r,     res_nxt;
  logic [DATA_W-1:0] rd_data_r;

  logic              can_load;
  logic              full_now;
  logic              fits;
  logic [LEN_W-1:0]  fill_inc;
  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len_clamp;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic              len_we;

  assign can_load  = !out_vld_r || res_ready;
  assign full_now  = (fill_r == '0) && !rej_r && (next_slot(tail_r) == head_r);
  assign fits      = fill_r < LEN_W'(MSG_BYTES);
  assign fill_inc  = fits ? fill_r + LEN_W'(1) : fill_r;
  assign len_raw   = len_mem[head_r];
  assign len_clamp = (len_raw > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES) : len_raw;
  assign mem_waddr = byte_addr(tail_r, fill_r);
  assign mem_raddr = byte_addr(pslot_r, idx_r);
  assign res_valid = out_vld_r;
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    fill_nxt    = fill_r;
    rej_nxt     = rej_r;
    ovf_nxt     = ovf_r;
    pslot_nxt   = pslot_r;
    plen_nxt    = plen_r;
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r && !res_ready;
    res_nxt     = res_r;
    q_ready     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    len_we      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && can_load) begin
          q_ready          = 1'b1;
          out_vld_nxt      = 1'b1;
          res_nxt.status   = STAT_OK;
          res_nxt.data     = '0;
          res_nxt.length   = '0;
          res_nxt.last     = 1'b1;
          case (q_item.kind)
            K_PUSH: begin
              if (rej_r || full_now) begin
                rej_nxt        = !q_item.last;
                res_nxt.status = STAT_FULL;
              end else begin
                mem_we   = fits;
                fill_nxt = fill_inc;
                if (!fits) begin
                  ovf_nxt        = 1'b1;
                  res_nxt.status = STAT_TRUNC;
                end
                if (q_item.last) begin
                  len_we         = 1'b1;
                  tail_nxt       = next_slot(tail_r);
                  count_nxt      = count_r + CNT_W'(1);
                  fill_nxt       = '0;
                  ovf_nxt        = 1'b0;
                  res_nxt.length = fill_inc;
                  if (ovf_r) begin
                    res_nxt.status = STAT_TRUNC;
                  end
                end
              end
            end
            K_POP, K_DROP: begin
              if (head_r == tail_r) begin
                res_nxt.status = STAT_EMPTY;
              end else begin
                head_nxt  = next_slot(head_r);
                count_nxt = count_r - CNT_W'(1);
                if (q_item.kind == K_DROP || len_clamp == '0) begin
                  res_nxt.length = len_clamp;
                end else begin
                  out_vld_nxt = out_vld_r && !res_ready;
                  state_nxt   = S_RD;
                  pslot_nxt   = head_r;
                  plen_nxt    = len_clamp;
                  idx_nxt     = '0;
                end
              end
            end
            default: begin
            end
          endcase
          res_nxt.occupancy = OCC_W'(count_nxt);
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          out_vld_nxt       = 1'b1;
          res_nxt.status    = STAT_OK;
          res_nxt.data      = rd_data_r;
          res_nxt.length    = plen_r;
          res_nxt.occupancy = OCC_W'(count_r);
          res_nxt.last      = (idx_r + LEN_W'(1) == plen_r);
          if (idx_r + LEN_W'(1) == plen_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      fill_r    <= '0;
      rej_r     <= 1'b0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      fill_r    <= fill_nxt;
      rej_r     <= rej_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= out_vld_nxt;
    end
    pslot_r <= pslot_nxt;
    plen_r  <= plen_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[mem_waddr] <= q_item.data;
    end
    if (mem_re) begin
      rd_data_r <= byte_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[tail_r] <= fill_inc;
    end
  end

  `MRQ_NEVER(a_count_range, count_r > CNT_W'(SLOTS - 1), "message count above capacity")
  `MRQ_ASSERT(a_empty_match, (head_r == tail_r) == (count_r == '0), "pointers vs count")
  `MRQ_ASSERT(a_pop_len, (state_r != S_IDLE) |-> (idx_r < plen_r), "pop index out of range")

endmodule

/* rtl/core/message_ring_queue.sv */
// Top level of the message ring queue: input stage, command queue, engine.
// Depends on mrq_pkg, mrq_front, mrq_queue and mrq_back.
//
// channel  dir  tdata                               tuser       tlast
// in_      in   [7:0] data_in                       [1:0] cmd   in_last
// out_     out  [7:0] data_out [14:8] msg_length     [1:0] status out_last
//               [18:15] occupancy
//
// Push, drop, empty and unused commands: one result each, loaded from the idle state.
// Pop of a message: a dispatch step, then per byte a byte RAM read (S_RD), then a
// result register load (S_EMIT) that waits while the output is stalled.
// Input register plus a two-entry queue absorb up to three transfers during a pop.
// Reset clears pointers, counters and control flags only; the byte and length stores are not
// cleared, so there is no clearing pass. Either side may stall at any time.
module message_ring_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mrq_pkg::DATA_W-1:0]        in_tdata,   // [7:0] data_in
  input  logic                              in_tlast,
  input  logic [mrq_pkg::CMD_W-1:0]         in_tuser,   // [1:0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mrq_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] data_out,
                                                        // [14:8] msg_length,
                                                        // [18:15] occupancy
  output logic                              out_tlast,
  output logic [mrq_pkg::STAT_W-1:0]        out_tuser   // [1:0] status
);
  import mrq_pkg::*;

  logic        f_valid;
  logic        f_ready;
  mrq_item_t   f_item;
  logic        q_valid;
  logic        q_ready;
  mrq_item_t   q_item;
  mrq_result_t res;

  mrq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  mrq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  mrq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {(OUT_TDATA_W - DATA_W - LEN_W - OCC_W)'(0),
                      res.occupancy, res.length, res.data};
  assign out_tlast = res.last;
  assign out_tuser = res.status;

endmodule

/* bench/tb_message_ring_queue.sv */
// Self-checking bench for message_ring_queue: push/pop/drop traffic with
// bursty input and a stalling receiver, results checked against a predictor.
// Depends on mrq_pkg and the message_ring_queue RTL.
`timescale 1ns / 1ps

module tb_message_ring_queue;
  import mrq_pkg::*;

  localparam int WDOG_LIMIT = 3000;
  localparam int TAIL_WAIT  = 20;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;     // [7:0] data_in
  logic                   in_tlast = 1'b0;
  logic [CMD_W-1:0]       in_tuser = '0;     // [1:0] cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [7:0] data_out, [14:8] msg_length,
                                             // [18:15] occupancy
  logic                   out_tlast;
  logic [STAT_W-1:0]      out_tuser;         // [1:0] status

  message_ring_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  mrq_item_t   cmd_backlog[$];
  mrq_result_t queued_replies[$];
  int          items_added = 0;
  int          items_taken = 0;
  int          err_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rdy_left = 0;
  int          idle_cycles = 0;

  // predictor state
  logic [DATA_W-1:0] msg_bytes [SLOTS*MSG_BYTES];
  logic [LEN_W-1:0]  msg_lens  [SLOTS];
  int                q_head = 0;
  int                q_tail = 0;
  logic [OCC_W-1:0]  q_count = '0;
  int                q_fill = 0;
  bit                q_rejecting = 1'b0;
  bit                q_overflowed = 1'b0;

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_reply(input logic [STAT_W-1:0] st, input logic [DATA_W-1:0] d,
                           input int len, input bit last);
    mrq_result_t r;
    r.status    = st;
    r.data      = d;
    r.length    = LEN_W'(len);
    r.last      = last;
    r.occupancy = q_count;
    queued_replies.push_back(r);
  endtask

  task automatic apply_cmd(input mrq_item_t it);
    logic [STAT_W-1:0] st;
    int h;
    int len;
    case (it.kind)
      K_PUSH: begin
        st = STAT_OK;
        if (q_fill == 0 && !q_rejecting && (q_tail + 1) % SLOTS == q_head)
          q_rejecting = 1'b1;
        if (q_rejecting) begin
          if (it.last) q_rejecting = 1'b0;
          add_reply(STAT_FULL, '0, 0, 1'b1);
        end else begin
          if (q_fill < MSG_BYTES) begin
            msg_bytes[q_tail*MSG_BYTES + q_fill] = it.data;
            q_fill++;
          end else begin
            q_overflowed = 1'b1;
            st = STAT_TRUNC;
          end
          if (it.last) begin
            len = q_fill;
            if (q_overflowed) st = STAT_TRUNC;
            msg_lens[q_tail] = LEN_W'(len);
            q_tail = (q_tail + 1) % SLOTS;
            q_count++;
            q_fill = 0;
            q_overflowed = 1'b0;
            add_reply(st, '0, len, 1'b1);
          end else begin
            add_reply(st, '0, 0, 1'b1);
          end
        end
      end
      K_POP, K_DROP: begin
        if (q_head == q_tail) begin
          add_reply(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          h = q_head;
          len = msg_lens[h];
          if (len > MSG_BYTES) len = MSG_BYTES;
          q_head = (h + 1) % SLOTS;
          q_count--;
          if (it.kind == K_DROP || len == 0) begin
            add_reply(STAT_OK, '0, len, 1'b1);
          end else begin
            for (int i = 0; i < len; i++)
              add_reply(STAT_OK, msg_bytes[h*MSG_BYTES + i], len, i == len - 1);
          end
        end
      end
      default: add_reply(STAT_OK, '0, 0, 1'b1);
    endcase
  endtask

  task automatic add_item(input mrq_kind_t k, input logic [DATA_W-1:0] d, input bit last);
    mrq_item_t it;
    it.kind = k;
    it.data = d;
    it.last = last;
    cmd_backlog.push_back(it);
    items_added++;
  endtask

  task automatic add_random(input int n);
    int added;
    int r;
    int len;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        r = $urandom_range(0, 19);
        if (r == 0) len = $urandom_range(60, 68);
        else if (r < 4) len = $urandom_range(9, 59);
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 11) == 0) begin
            r = $urandom_range(0, 9);
            add_item(r < 5 ? K_POP : (r < 9 ? K_DROP : K_NOP), DATA_W'($urandom),
                     1'($urandom));
            added++;
          end
          add_item(K_PUSH, DATA_W'($urandom), i == len - 1);
          added++;
        end
      end else begin
        if (r < 78) add_item(K_POP, DATA_W'($urandom), 1'($urandom));
        else if (r < 93) add_item(K_DROP, DATA_W'($urandom), 1'($urandom));
        else add_item(K_NOP, DATA_W'($urandom), 1'($urandom));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (items_taken != items_added) @(posedge clk);
    while (queued_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : drv
    mrq_item_t cur;
    mrq_item_t nxt;
    bit        drive;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        cur.kind = mrq_kind_t'(in_tuser);
        cur.data = in_tdata;
        cur.last = in_tlast;
        apply_cmd(cur);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        drive = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          drive = 1'b1;
          in_tuser <= CMD_W'(nxt.kind);
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
          end
        end
        in_tvalid <= drive;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_left   = 0;
    end else if (rdy_left == 0) begin
      if (out_tready) begin
        out_tready <= 1'b0;
        rdy_left   = $urandom_range(1, 6);
      end else begin
        out_tready <= 1'b1;
        rdy_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 20);
      end
    end else begin
      rdy_left--;
    end
  end

  always @(posedge clk) begin : mon
    mrq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (queued_replies.size() == 0) begin
        report_err($sformatf("result with nothing pending: status %0d tdata %h last %b",
                             out_tuser, out_tdata, out_tlast));
      end else begin
        want = queued_replies.pop_front();
        if (out_tuser !== want.status)
          report_err($sformatf("status got %0d exp %0d", out_tuser, want.status));
        if (out_tdata[7:0] !== want.data)
          report_err($sformatf("data_out got %h exp %h", out_tdata[7:0], want.data));
        if (out_tdata[14:8] !== want.length)
          report_err($sformatf("msg_length got %0d exp %0d", out_tdata[14:8], want.length));
        if (out_tlast !== want.last)
          report_err($sformatf("out_last got %b exp %b", out_tlast, want.last));
        if (out_tdata[18:15] !== want.occupancy)
          report_err($sformatf("occupancy got %0d exp %0d", out_tdata[18:15],
                               want.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, unused command, fill to capacity, reject while full
    add_item(K_POP, 8'h00, 1'b0);
    add_item(K_DROP, 8'hFF, 1'b1);
    add_item(K_NOP, 8'hFF, 1'b1);
    for (int i = 0; i < SLOTS - 1; i++)
      add_item(K_PUSH, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : DATA_W'(1 << (i % 8)), 1'b1);
    add_item(K_PUSH, 8'hA5, 1'b0);
    add_item(K_POP, 8'h00, 1'b0);
    add_item(K_PUSH, 8'h5A, 1'b1);
    add_item(K_PUSH, 8'h7E, 1'b1);
    add_item(K_DROP, 8'h00, 1'b0);
    add_item(K_POP, 8'h00, 1'b0);
    add_item(K_PUSH, 8'hAA, 1'b0);
    add_item(K_POP, 8'h00, 1'b0);
    add_item(K_PUSH, 8'h55, 1'b1);
    wait_drained();

    // drain the ring so the long messages below are not rejected
    for (int i = 0; i < SLOTS - 1; i++)
      add_item(K_DROP, 8'h00, 1'b0);

    // one full-size and one oversized message, then random traffic
    for (int i = 0; i < MSG_BYTES; i++)
      add_item(K_PUSH, DATA_W'($urandom), i == MSG_BYTES - 1);
    for (int i = 0; i < MSG_BYTES + 2; i++)
      add_item(K_PUSH, DATA_W'($urandom), i == MSG_BYTES + 1);
    add_random(150);
    wait_drained();
    add_random(150);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);
    if (queued_replies.size() != 0)
      report_err($sformatf("%0d results never arrived", queued_replies.size()));
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
